// ===== src/vfr_pkg.sv =====
package vfr_pkg;

    localparam logic [20:0] CAPACITY_RESET = 21'd131072;

    localparam logic [2:0] ST_STORED      = 3'd0;
    localparam logic [2:0] ST_DUPLICATE   = 3'd1;
    localparam logic [2:0] ST_OUT_OF_ORDER = 3'd2;
    localparam logic [2:0] ST_OVERFLOW    = 3'd3;
    localparam logic [2:0] ST_BEYOND_LIMIT = 3'd4;
    localparam logic [2:0] ST_FLUSHED     = 3'd5;
    localparam logic [2:0] ST_NO_FLUSH    = 3'd6;

    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] frame_number;
        logic [7:0]  part_number;
        logic        is_last;
        logic [7:0]  frame_resolution;
        logic [15:0] payload_length;
    } t_vfr_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [19:0] write_offset;
        logic        prior_abandoned;
        logic        frame_done;
        logic [20:0] done_size;
        logic [31:0] done_frame;
        logic [7:0]  done_resolution;
        logic [31:0] completed_count;
        logic [31:0] abandoned_count;
    } t_vfr_out;

    // item plus what the front already decided about it
    typedef struct packed {
        t_vfr_in item;
        logic    is_flush;
        logic    in_range;
    } t_vfr_job;

endpackage

// ===== src/video_fragment_reassembler_unit.sv =====
// The item is written into the queue, then its result into the engine output register.
// Throughput: one item per cycle unless the output stalls; frame state updates on each pop.
// A 2-entry queue decouples input stall from output stall.
// Reset (i_rst_n low, synchronous): queue empty, frame state and counters zero,
// buffer capacity back to 131072.
module video_fragment_reassembler_unit #(
    parameter int MAX_PARTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [20:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  vfr_pkg::t_vfr_in   i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output vfr_pkg::t_vfr_out  o_out_item
);

    logic              job_valid;
    logic              job_pop;
    vfr_pkg::t_vfr_job job;

    vfr_front #(
        .MAX_PARTS (MAX_PARTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_item      (i_in_item),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    vfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_item      (o_out_item)
    );

endmodule

// ===== src/vfr_front.sv =====
module vfr_front #(
    parameter int MAX_PARTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  vfr_pkg::t_vfr_in   i_item,
    output logic               o_job_valid,
    output vfr_pkg::t_vfr_job  o_job,
    input  logic               i_job_pop
);

    vfr_pkg::t_vfr_job r_mem [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_count;
    logic              push;
    vfr_pkg::t_vfr_job job_in;

    assign o_stall     = (r_count == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_mem[r_rptr];

    always_comb begin
        job_in.item     = i_item;
        job_in.is_flush = (i_item.cmd == vfr_pkg::CMD_FLUSH);
        job_in.in_range = ({1'b0, i_item.part_number} < 9'(MAX_PARTS));
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= job_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (i_job_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({push, i_job_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/vfr_back.sv =====
module vfr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [20:0]        i_cfg_wdata,
    input  logic               i_job_valid,
    input  vfr_pkg::t_vfr_job  i_job,
    output logic               o_job_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output vfr_pkg::t_vfr_out  o_item
);

    logic [20:0]       r_capacity;
    logic [31:0]       r_cur_frame;
    logic [7:0]        r_cur_res;
    logic [8:0]        r_stored;
    logic [8:0]        r_expected;
    logic [20:0]       r_size;
    logic [31:0]       r_completed;
    logic [31:0]       r_abandoned;
    logic              r_out_valid;
    vfr_pkg::t_vfr_out r_out;

    logic [31:0]       n_cur_frame;
    logic [7:0]        n_cur_res;
    logic [8:0]        n_stored;
    logic [8:0]        n_expected;
    logic [20:0]       n_size;
    logic [31:0]       n_completed;
    logic [31:0]       n_abandoned;
    vfr_pkg::t_vfr_out n_out;

    logic pop;

    assign pop       = i_job_valid && (!r_out_valid || !i_stall);
    assign o_job_pop = pop;
    assign o_valid   = r_out_valid;
    assign o_item    = r_out;

    always_comb begin
        vfr_pkg::t_vfr_in it;
        logic        new_frame;
        logic        abandon;
        logic        dup;
        logic        fit;
        logic        check;
        logic        done;
        logic [8:0]  part9;
        logic [21:0] sum;

        it          = i_job.item;
        n_cur_frame = r_cur_frame;
        n_cur_res   = r_cur_res;
        n_stored    = r_stored;
        n_expected  = r_expected;
        n_size      = r_size;
        abandon     = 1'b0;
        done        = 1'b0;
        check       = 1'b0;
        dup         = 1'b0;
        fit         = 1'b0;
        new_frame   = 1'b0;
        part9       = {1'b0, it.part_number};
        sum         = 22'd0;
        n_out       = '0;

        if (i_job.is_flush) begin
            if (r_stored != 9'd0) begin
                abandon     = 1'b1;
                n_cur_frame = 32'd0;
                n_cur_res   = 8'd0;
                n_stored    = 9'd0;
                n_expected  = 9'd0;
                n_size      = 21'd0;
                n_out.status = vfr_pkg::ST_FLUSHED;
            end else begin
                n_out.status = vfr_pkg::ST_NO_FLUSH;
            end
        end else begin
            new_frame = (it.frame_number != r_cur_frame);
            if (new_frame) begin
                abandon     = (r_stored != 9'd0);
                n_cur_frame = it.frame_number;
                n_cur_res   = it.frame_resolution;
                n_stored    = 9'd0;
                n_expected  = 9'd0;
                n_size      = 21'd0;
            end
            sum = {1'b0, n_size} + 22'(it.payload_length);
            fit = (sum <= {1'b0, r_capacity});
            dup = (part9 < n_stored);
            if (dup) begin
                n_out.status = vfr_pkg::ST_DUPLICATE;
            end else begin
                if (it.is_last) begin
                    n_expected = part9 + 9'd1;
                end
                if (!i_job.in_range) begin
                    n_out.status = vfr_pkg::ST_BEYOND_LIMIT;
                    check        = 1'b1;
                end else if (part9 != n_stored) begin
                    n_out.status = vfr_pkg::ST_OUT_OF_ORDER;
                end else if (!fit) begin
                    n_out.status = vfr_pkg::ST_OVERFLOW;
                end else begin
                    n_out.status       = vfr_pkg::ST_STORED;
                    n_out.write_offset = n_size[19:0];
                    n_stored           = n_stored + 9'd1;
                    n_size             = sum[20:0];
                    check              = 1'b1;
                end
            end
            done = check && (n_expected != 9'd0) && (n_stored >= n_expected);
            if (done) begin
                n_out.done_size       = n_size;
                n_out.done_frame      = n_cur_frame;
                n_out.done_resolution = n_cur_res;
                n_cur_frame = 32'd0;
                n_cur_res   = 8'd0;
                n_stored    = 9'd0;
                n_expected  = 9'd0;
                n_size      = 21'd0;
            end
        end

        n_completed = r_completed + {31'd0, done};
        n_abandoned = r_abandoned + {31'd0, abandon};

        n_out.prior_abandoned = abandon;
        n_out.frame_done      = done;
        n_out.completed_count = n_completed;
        n_out.abandoned_count = n_abandoned;
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= vfr_pkg::CAPACITY_RESET;
            r_cur_frame <= 32'd0;
            r_cur_res   <= 8'd0;
            r_stored    <= 9'd0;
            r_expected  <= 9'd0;
            r_size      <= 21'd0;
            r_completed <= 32'd0;
            r_abandoned <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (pop) begin
                r_cur_frame <= n_cur_frame;
                r_cur_res   <= n_cur_res;
                r_stored    <= n_stored;
                r_expected  <= n_expected;
                r_size      <= n_size;
                r_completed <= n_completed;
                r_abandoned <= n_abandoned;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== test/vfr_checker.sv =====
module vfr_checker
    import vfr_pkg::*;
#(
    parameter int MAX_PARTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [20:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_vfr_in     i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_vfr_out    i_out_item,
    output logic [31:0] o_fail_count,
    output logic [31:0] o_pending,
    output logic [31:0] o_checked
);

    localparam int PRINT_LIMIT = 25;

    logic [20:0] buffer_capacity;
    logic [31:0] current_frame;
    logic [7:0]  current_resolution;
    logic [8:0]  parts_stored;
    logic [8:0]  parts_expected;
    logic [20:0] running_size;
    logic [31:0] frames_completed;
    logic [31:0] frames_abandoned;

    t_vfr_out expected_results[$];
    t_vfr_out want;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_checked = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_LIMIT) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        o_fail_count = o_fail_count + 1;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("result %0d field %s got 0x%0h want 0x%0h",
                                      o_checked, name, got, exp_val));
        end
    endtask

    function automatic void clear_frame();
        current_frame = '0;
        current_resolution = '0;
        parts_stored = '0;
        parts_expected = '0;
        running_size = '0;
    endfunction

    // works out the result of one item and advances the frame state
    function automatic t_vfr_out reassemble(input t_vfr_in it);
        t_vfr_out r;
        logic run_check;
        logic [21:0] sum;
        r = '0;
        run_check = 1'b1;
        if (it.cmd == CMD_FLUSH) begin
            if (parts_stored != 0) begin
                frames_abandoned++;
                clear_frame();
                r.prior_abandoned = 1'b1;
                r.status = ST_FLUSHED;
            end else begin
                r.status = ST_NO_FLUSH;
            end
        end else begin
            if (it.frame_number != current_frame) begin
                if (parts_stored != 0) begin
                    frames_abandoned++;
                    r.prior_abandoned = 1'b1;
                end
                clear_frame();
                current_frame = it.frame_number;
                current_resolution = it.frame_resolution;
            end
            if ({1'b0, it.part_number} < parts_stored) begin
                r.status = ST_DUPLICATE;
                run_check = 1'b0;
            end else begin
                if (it.is_last) begin
                    parts_expected = {1'b0, it.part_number} + 9'd1;
                end
                if (int'(it.part_number) < MAX_PARTS) begin
                    sum = {1'b0, running_size} + {6'd0, it.payload_length};
                    if ({1'b0, it.part_number} != parts_stored) begin
                        r.status = ST_OUT_OF_ORDER;
                        run_check = 1'b0;
                    end else if (sum > {1'b0, buffer_capacity}) begin
                        r.status = ST_OVERFLOW;
                        run_check = 1'b0;
                    end else begin
                        r.status = ST_STORED;
                        r.write_offset = running_size[19:0];
                        parts_stored++;
                        running_size = sum[20:0];
                    end
                end else begin
                    // not stored, but the completion check still runs
                    r.status = ST_BEYOND_LIMIT;
                end
            end
            if (run_check && parts_expected != 0 && parts_stored >= parts_expected) begin
                frames_completed++;
                r.frame_done = 1'b1;
                r.done_size = running_size;
                r.done_frame = current_frame;
                r.done_resolution = current_resolution;
                clear_frame();
            end
        end
        r.completed_count = frames_completed;
        r.abandoned_count = frames_abandoned;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            buffer_capacity = CAPACITY_RESET;
            clear_frame();
            frames_completed = '0;
            frames_abandoned = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                buffer_capacity = i_cfg_wdata;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with no item waiting, status %0d",
                                              i_out_item.status));
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", 32'(i_out_item.status), 32'(want.status));
                    compare_field("write_offset", 32'(i_out_item.write_offset),
                                  32'(want.write_offset));
                    compare_field("prior_abandoned", 32'(i_out_item.prior_abandoned),
                                  32'(want.prior_abandoned));
                    compare_field("frame_done", 32'(i_out_item.frame_done),
                                  32'(want.frame_done));
                    compare_field("done_size", 32'(i_out_item.done_size),
                                  32'(want.done_size));
                    compare_field("done_frame", i_out_item.done_frame, want.done_frame);
                    compare_field("done_resolution", 32'(i_out_item.done_resolution),
                                  32'(want.done_resolution));
                    compare_field("completed_count", i_out_item.completed_count,
                                  want.completed_count);
                    compare_field("abandoned_count", i_out_item.abandoned_count,
                                  want.abandoned_count);
                    o_checked = o_checked + 1;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(reassemble(i_in_item));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== test/testbench.sv =====
module testbench;
    import vfr_pkg::*;

    localparam int MAX_PARTS = 64;
    localparam int HOLD_CYCLES = 60;
    localparam int TOTAL_ITEMS = 1650;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [20:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    t_vfr_in     i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_vfr_out    o_out_item;

    wire [31:0] fail_count;
    wire [31:0] pending;
    wire [31:0] checked;

    int          items_sent;
    logic [31:0] next_frame;
    bit          no_idle;
    int          hold_requests;
    int          hold_served;

    logic [20:0] capacities[5];
    int          budgets[5];
    int          ph;

    video_fragment_reassembler_unit #(
        .MAX_PARTS(MAX_PARTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    vfr_checker #(
        .MAX_PARTS(MAX_PARTS)
    ) chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_item  (o_out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

    // receiver: random stall, plus long hold-offs on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_served) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_served++;
            end else begin
                i_out_stall <= !no_idle && ($urandom_range(99) < 24);
            end
        end
    end

    function automatic t_vfr_in make_header(input logic [31:0] fnum, input logic [7:0] part,
                                            input logic last, input logic [7:0] res,
                                            input logic [15:0] len);
        t_vfr_in it;
        it.cmd = CMD_HEADER;
        it.frame_number = fnum;
        it.part_number = part;
        it.is_last = last;
        it.frame_resolution = res;
        it.payload_length = len;
        return it;
    endfunction

    function automatic t_vfr_in random_item();
        t_vfr_in it;
        it.cmd = 1'($urandom_range(1));
        it.frame_number = $urandom;
        it.part_number = 8'($urandom_range(255));
        it.is_last = 1'($urandom_range(1));
        it.frame_resolution = 8'($urandom_range(255));
        it.payload_length = 16'($urandom_range(65535));
        return it;
    endfunction

    function automatic t_vfr_in flush_item();
        t_vfr_in it;
        it = random_item();
        it.cmd = CMD_FLUSH;
        return it;
    endfunction

    function automatic logic [15:0] rand_length();
        int r;
        r = $urandom_range(99);
        if (r < 30) return 16'd0;
        if (r < 70) return 16'($urandom_range(1023));
        return 16'($urandom_range(65535));
    endfunction

    task automatic send_item(input t_vfr_in it);
        while (!no_idle && $urandom_range(99) < 24) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [20:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one frame in order, with occasional duplicates, skips and early exits
    task automatic send_frame();
        logic [31:0] fnum;
        logic [7:0]  res;
        int nparts;
        int r;
        int p;
        bit big;
        r = $urandom_range(99);
        if (r < 70) begin
            fnum = next_frame;
            next_frame++;
        end else if (r < 80) begin
            fnum = 32'd0;
        end else begin
            fnum = $urandom;
        end
        res = 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 70) nparts = $urandom_range(6, 1);
        else if (r < 90) nparts = $urandom_range(20, 7);
        else if (r < 97) nparts = $urandom_range(40, 21);
        else nparts = $urandom_range(70, 60);
        big = (nparts > 20) && (nparts <= 40);
        for (p = 0; p < nparts; p++) begin
            r = $urandom_range(99);
            if (r < 4 && p > 0) begin
                send_item(make_header(fnum, 8'($urandom_range(p - 1)),
                                      1'($urandom_range(1)), res, rand_length()));
            end else if (r < 7) begin
                send_item(make_header(fnum, 8'(p + $urandom_range(3, 1)),
                                      1'($urandom_range(1)), res, rand_length()));
            end else if (r == 7) begin
                break;
            end
            send_item(make_header(fnum, 8'(p), p == nparts - 1, res,
                                  big ? 16'($urandom_range(65535, 30000)) : rand_length()));
        end
        if ($urandom_range(9) == 0) send_item(flush_item());
    endtask

    task automatic run_random(input int budget);
        int stop_at;
        int r;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 8) send_item(random_item());
            else if (r < 12) send_item(flush_item());
            else send_frame();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        items_sent = 0;
        next_frame = 32'd100;
        no_idle = 1'b0;
        hold_requests = 0;
        hold_served = 0;
        capacities = '{21'd1048576, 21'd0, 21'h1FFFFF, 21'd5000, CAPACITY_RESET};
        budgets = '{400, 150, 400, 350, 0};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, at the reset capacity
        send_item(flush_item());
        // frame 0 continues the cleared state and keeps resolution 0
        send_item(make_header(32'd0, 8'd0, 1'b0, 8'h3C, 16'd100));
        send_item(make_header(32'd0, 8'd0, 1'b0, 8'h3C, 16'd7));
        send_item(make_header(32'd0, 8'd2, 1'b1, 8'h3C, 16'd7));
        send_item(make_header(32'd0, 8'd1, 1'b0, 8'h3C, 16'd0));
        send_item(make_header(32'd0, 8'd2, 1'b1, 8'h3C, 16'hFFFF));
        send_item(make_header(32'hFFFFFFFF, 8'd0, 1'b0, 8'hFF, 16'hFFFF));
        send_item(make_header(32'hFFFFFFFF, 8'd1, 1'b0, 8'hFF, 16'hFFFF));
        send_item(make_header(32'hFFFFFFFF, 8'd2, 1'b1, 8'hFF, 16'd3));
        send_item(make_header(32'hFFFFFFFF, 8'd2, 1'b1, 8'hFF, 16'd2));
        send_item(make_header(32'h12345678, 8'd0, 1'b0, 8'h11, 16'd10));
        send_item(make_header(32'hEDCBA987, 8'd0, 1'b0, 8'hEE, 16'd20));
        send_item(flush_item());
        send_item(make_header(32'd5, 8'd200, 1'b1, 8'h55, 16'd1));
        send_item(make_header(32'd5, 8'd63, 1'b1, 8'h55, 16'd1));
        send_item(make_header(32'd5, 8'd255, 1'b1, 8'h55, 16'hFFFF));
        send_item(make_header(32'd5, 8'd64, 1'b0, 8'h55, 16'd0));
        send_item(make_header(32'd7, 8'd0, 1'b1, 8'h81, 16'hFFFF));
        send_item(flush_item());
        send_item(make_header(32'd9, 8'd0, 1'b0, 8'hAA, 16'h5A5A));
        send_item(make_header(32'd9, 8'd1, 1'b1, 8'hAA, 16'hA5A5));

        for (ph = 0; ph < 5; ph++) begin
            set_capacity(capacities[ph]);
            no_idle = (ph == 2);
            if (ph == 0 || ph == 3) hold_requests++;
            run_random(ph == 4 ? TOTAL_ITEMS - items_sent : budgets[ph]);
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("covered %0d items, %0d results checked, over capacities 0 to 2097151",
                 items_sent, checked);
        $display("stimulus mixed in-order frames with duplicates, gaps, flushes and hold-offs");
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/vfr_pkg.sv
src/vfr_front.sv
src/vfr_back.sv
src/video_fragment_reassembler_unit.sv
test/vfr_checker.sv
test/testbench.sv
